@@ rtl/ccr_pkg.sv @@
// Shared types and constants for the Costas carrier recovery block.
package ccr_pkg;

  localparam int GAIN_BITS    = 16;
  localparam int FREQ_BITS    = 32;
  localparam int CFG_IDX_BITS = 2;

  // Register indexes on the configuration port
  localparam logic [CFG_IDX_BITS-1:0] CFG_MODE  = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_ALPHA = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_BETA  = 2'd2;

  // Phase detector selection
  localparam logic MODE_BPSK = 1'b0;
  localparam logic MODE_QPSK = 1'b1;

  // Sine table generation, Q30
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
  localparam logic [63:0] ONE_Q30     = 64'd1 << 30;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_COS,
    ST_CAPC,
    ST_MUL_A,
    ST_MUL_B,
    ST_RND_Q,
    ST_ERR,
    ST_GAIN,
    ST_FREQ,
    ST_PHASE,
    ST_DONE
  } ccr_state_t;

  typedef enum logic [1:0] {
    MUL_CROSS_A,
    MUL_CROSS_B,
    MUL_GAIN
  } ccr_mul_sel_t;

  typedef struct packed {
    logic         load;
    logic         cos_sel;
    logic         cap_sin;
    logic         cap_cos;
    ccr_mul_sel_t mul_sel;
    logic         mul_en;
    logic         di_en;
    logic         dq_en;
    logic         err_en;
    logic         freq_en;
    logic         phase_en;
    logic         out_load;
  } ccr_cmd_t;

endpackage

@@ rtl/ccr_datapath.sv @@
// Datapath: sine ROM, derotation, phase detector, loop filter and output words.
module ccr_datapath import ccr_pkg::*; #(
  parameter int SAMPLE_BITS   = 16,
  parameter int PHASE_BITS    = 32,
  parameter int LUT_ADDR_BITS = 10,
  parameter int GAIN_SHIFT    = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  ccr_cmd_t                      cmd,
  input  logic                          cfg_we,
  input  logic [CFG_IDX_BITS-1:0]       cfg_index,
  input  logic [GAIN_BITS-1:0]          cfg_data,
  input  logic signed [SAMPLE_BITS-1:0] sample_i,
  input  logic signed [SAMPLE_BITS-1:0] sample_q,
  output logic signed [SAMPLE_BITS-1:0] derot_i,
  output logic signed [SAMPLE_BITS-1:0] derot_q,
  output logic signed [FREQ_BITS-1:0]   freq_estimate
);

  localparam int SB       = SAMPLE_BITS;
  localparam int RW       = SB - 1;
  localparam int LA       = LUT_ADDR_BITS;
  localparam int LUT_SIZE = 1 << LA;
  localparam int IW       = LA + 2;
  localparam int EW       = SB + 2;
  localparam int AW       = EW;
  localparam int BW       = (SB > GAIN_BITS + 1) ? SB : GAIN_BITS + 1;
  localparam int PW       = AW + BW;
  localparam int RSW      = PW + 1;
  localparam int FW       = ((PW > FREQ_BITS) ? PW : FREQ_BITS) + 1;

  localparam logic [63:0]           AMP64  = 64'((1 << (SB - 1)) - 1);
  localparam logic signed [SB-1:0]  AMP_S  = SB'((1 << (SB - 1)) - 1);
  localparam logic signed [RSW-1:0] R_MAX  = RSW'((1 << (SB - 1)) - 1);
  localparam logic signed [RSW-1:0] R_MIN  = -R_MAX - RSW'(1);
  localparam logic signed [RSW-1:0] R_HALF = RSW'(1 << (SB - 2));
  localparam logic signed [FW-1:0]  F_MAX  = FW'(2147483647);
  localparam logic signed [FW-1:0]  F_MIN  = -F_MAX - FW'(1);

  typedef logic [RW-1:0] rom_t [LUT_SIZE];

  // Quarter-wave sine, Taylor series through x^13 in Q30, scaled and rounded
  function automatic rom_t build_rom();
    rom_t        rom;
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] t;
    logic [63:0] s;
    for (int k = 0; k < LUT_SIZE; k++) begin
      x  = (HALF_PI_Q30 * 64'(k)) / 64'(LUT_SIZE);
      x2 = (x * x) >> 30;
      t  = ONE_Q30;
      t  = ONE_Q30 - ((x2 * t) >> 30) / 64'd156;
      t  = ONE_Q30 - ((x2 * t) >> 30) / 64'd110;
      t  = ONE_Q30 - ((x2 * t) >> 30) / 64'd72;
      t  = ONE_Q30 - ((x2 * t) >> 30) / 64'd42;
      t  = ONE_Q30 - ((x2 * t) >> 30) / 64'd20;
      t  = ONE_Q30 - ((x2 * t) >> 30) / 64'd6;
      s  = (x * t) >> 30;
      rom[k] = RW'((s * AMP64 + (64'd1 << 29)) >> 30);
    end
    return rom;
  endfunction

  localparam rom_t SINE_ROM = build_rom();

  function automatic logic signed [SB-1:0] round_sat(input logic signed [RSW-1:0] acc);
    logic signed [RSW-1:0] r;
    r = (acc + R_HALF) >>> (SB - 1);
    if (r > R_MAX) begin
      r = R_MAX;
    end else if (r < R_MIN) begin
      r = R_MIN;
    end
    return SB'(r);
  endfunction

  // Configuration and loop state
  logic                  mode;
  logic [GAIN_BITS-1:0]  loop_alpha;
  logic [GAIN_BITS-1:0]  loop_beta;
  logic [PHASE_BITS-1:0] phase_acc;
  logic signed [FREQ_BITS-1:0] freq_acc;

  logic signed [SB-1:0]  smp_i, smp_q;
  logic signed [SB-1:0]  sin_v, cos_v;
  logic signed [SB-1:0]  di, dq;
  logic signed [EW-1:0]  err;
  logic signed [PW-1:0]  m0, m1;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode       <= MODE_BPSK;
      loop_alpha <= '0;
      loop_beta  <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_MODE:  mode       <= cfg_data[0];
        CFG_ALPHA: loop_alpha <= cfg_data;
        CFG_BETA:  loop_beta  <= cfg_data;
        default:   ;
      endcase
    end
  end

  // Table lookup: quadrant from the top two index bits, odd quadrants mirrored
  logic [IW-1:0] idx;
  logic [1:0]    quad_s, quad_c, quad;
  logic [LA-1:0] k_pos, k_neg, rom_addr;
  logic          full_d;
  logic [RW-1:0] rom_q;
  logic          rom_full, rom_neg;
  logic signed [SB-1:0] trig_mag, trig_val;

  assign idx      = phase_acc[PHASE_BITS-1 -: IW];
  assign quad_s   = idx[IW-1:LA];
  assign quad_c   = quad_s + 2'd1;
  assign quad     = cmd.cos_sel ? quad_c : quad_s;
  assign k_pos    = idx[LA-1:0];
  assign k_neg    = ~k_pos + 1'b1;
  assign rom_addr = quad[0] ? k_neg : k_pos;
  assign full_d   = quad[0] && (k_pos == '0);

  always_ff @(posedge clk) begin
    rom_q    <= SINE_ROM[rom_addr];
    rom_full <= full_d;
    rom_neg  <= quad[1];
  end

  assign trig_mag = rom_full ? AMP_S : signed'({1'b0, rom_q});
  assign trig_val = rom_neg ? -trig_mag : trig_mag;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      smp_i <= sample_i;
      smp_q <= sample_q;
    end
    if (cmd.cap_sin) begin
      sin_v <= trig_val;
    end
    if (cmd.cap_cos) begin
      cos_v <= trig_val;
    end
  end

  // Shared pair of multipliers
  logic signed [AW-1:0] a0, a1;
  logic signed [BW-1:0] b0, b1;

  always_comb begin
    case (cmd.mul_sel)
      MUL_CROSS_A: begin
        a0 = AW'(smp_i);
        b0 = BW'(cos_v);
        a1 = AW'(smp_q);
        b1 = BW'(sin_v);
      end
      MUL_CROSS_B: begin
        a0 = AW'(smp_q);
        b0 = BW'(cos_v);
        a1 = AW'(smp_i);
        b1 = BW'(sin_v);
      end
      MUL_GAIN: begin
        a0 = err;
        b0 = BW'(signed'({1'b0, loop_beta}));
        a1 = err;
        b1 = BW'(signed'({1'b0, loop_alpha}));
      end
      default: begin
        a0 = '0;
        b0 = '0;
        a1 = '0;
        b1 = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.mul_en) begin
      m0 <= a0 * b0;
      m1 <= a1 * b1;
    end
  end

  // Derotation round and saturate, then phase detector
  logic signed [RSW-1:0] sum_i, sum_q;
  logic signed [EW-1:0]  bpsk_e, qpsk_t, err_next;

  assign sum_i    = RSW'(m0) + RSW'(m1);
  assign sum_q    = RSW'(m0) - RSW'(m1);
  assign bpsk_e   = (di > 0) ? EW'(dq) : -EW'(dq);
  assign qpsk_t   = (dq > 0) ? EW'(di) : -EW'(di);
  assign err_next = (mode == MODE_QPSK) ? (qpsk_t - bpsk_e) : bpsk_e;

  always_ff @(posedge clk) begin
    if (cmd.di_en) begin
      di <= round_sat(sum_i);
    end
    if (cmd.dq_en) begin
      dq <= round_sat(sum_q);
    end
    if (cmd.err_en) begin
      err <= err_next;
    end
  end

  // Loop filter
  logic signed [FW-1:0]        f_sum;
  logic signed [FREQ_BITS-1:0] freq_next;
  logic [PHASE_BITS-1:0]       phase_next;
  logic signed [PW-1:0]        f_inc, prop;

  assign f_inc = m0 >>> GAIN_SHIFT;
  assign prop  = m1 >>> GAIN_SHIFT;
  assign f_sum = FW'(freq_acc) + FW'(f_inc);

  always_comb begin
    if (f_sum > F_MAX) begin
      freq_next = FREQ_BITS'(F_MAX);
    end else if (f_sum < F_MIN) begin
      freq_next = FREQ_BITS'(F_MIN);
    end else begin
      freq_next = FREQ_BITS'(f_sum);
    end
  end

  assign phase_next = phase_acc + PHASE_BITS'(freq_acc) + PHASE_BITS'(prop);

  always_ff @(posedge clk) begin
    if (rst) begin
      freq_acc  <= '0;
      phase_acc <= '0;
    end else begin
      if (cmd.freq_en) begin
        freq_acc <= freq_next;
      end
      if (cmd.phase_en) begin
        phase_acc <= phase_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      derot_i       <= di;
      derot_q       <= dq;
      freq_estimate <= freq_acc;
    end
  end

endmodule

@@ rtl/ccr_ctrl.sv @@
// Controller: sequences one sample through the datapath and owns the output valid.
module ccr_ctrl import ccr_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_stall,
  output logic     out_valid,
  input  logic     out_stall,
  output ccr_cmd_t cmd
);

  ccr_state_t state, state_next;
  logic       slot_free;
  logic       out_valid_next;

  assign slot_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  assign out_valid_next = cmd.out_load || (out_valid && out_stall);

  always_comb begin
    case (state)
      ST_IDLE:  state_next = in_valid ? ST_COS : ST_IDLE;
      ST_COS:   state_next = ST_CAPC;
      ST_CAPC:  state_next = ST_MUL_A;
      ST_MUL_A: state_next = ST_MUL_B;
      ST_MUL_B: state_next = ST_RND_Q;
      ST_RND_Q: state_next = ST_ERR;
      ST_ERR:   state_next = ST_GAIN;
      ST_GAIN:  state_next = ST_FREQ;
      ST_FREQ:  state_next = ST_PHASE;
      ST_PHASE: state_next = slot_free ? ST_IDLE : ST_DONE;
      ST_DONE:  state_next = slot_free ? ST_IDLE : ST_DONE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    case (state)
      ST_IDLE: begin
        in_stall = rst;
        cmd.load = in_valid && !rst;
      end
      ST_COS: begin
        cmd.cos_sel = 1'b1;
        cmd.cap_sin = 1'b1;
      end
      ST_CAPC: begin
        cmd.cap_cos = 1'b1;
      end
      ST_MUL_A: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_CROSS_A;
      end
      ST_MUL_B: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_CROSS_B;
        cmd.di_en   = 1'b1;
      end
      ST_RND_Q: begin
        cmd.dq_en = 1'b1;
      end
      ST_ERR: begin
        cmd.err_en = 1'b1;
      end
      ST_GAIN: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_GAIN;
      end
      ST_FREQ: begin
        cmd.freq_en = 1'b1;
      end
      ST_PHASE: begin
        cmd.phase_en = 1'b1;
        cmd.out_load = slot_free;
      end
      ST_DONE: begin
        cmd.out_load = slot_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

  // A waiting result is never overwritten
  assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> !(out_valid && out_stall))
    else $error("output word overwritten while stalled");

  // An accepted word starts the sequence
  assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> (state == ST_COS))
    else $error("accepted word did not start processing");

  // A result appears only at the end of a loop update
  assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> ($past(state) == ST_PHASE || $past(state) == ST_DONE))
    else $error("output valid raised outside the update");

endmodule

@@ rtl/costas_carrier_recovery.sv @@
// Top level of the Costas carrier recovery block for BPSK and QPSK.
//
// Usage:
//   Input channel (in_valid, in_stall, sample_i, sample_q) takes one complex
//   Q1.15 word. Output channel (out_valid, out_stall, derot_i, derot_q,
//   freq_estimate) returns the derotated word and the frequency accumulator
//   after the loop update, one result per input word, in order.
//   Configuration port (cfg_valid, cfg_ready, cfg_index, cfg_data) writes
//   mode (index 0), loop_alpha (1) and loop_beta (2); other indexes drop.
//   Write registers only while the block is idle.
// Sequence:
//   Each word is accepted in idle and then takes nine steps of the
//   controller (two ROM reads on the single table port, two passes through
//   the shared multiplier pair for derotation, round for Q, phase error, one
//   gain pass, frequency update, phase update). The output register loads
//   in the phase update step, or once a held word is taken. The next word
//   is taken only back in idle, since the phase it needs closes with the update.
// Reset and stall:
//   rst clears phase, frequency, registers and output valid; in_stall is
//   high during reset. A stalled result holds in the output register while
//   the next word is accepted and processed; the new result then waits in
//   the datapath until the receiver takes the held word.
module costas_carrier_recovery import ccr_pkg::*; #(
  parameter int SAMPLE_BITS   = 16,
  parameter int PHASE_BITS    = 32,
  parameter int LUT_ADDR_BITS = 10,
  parameter int GAIN_SHIFT    = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [SAMPLE_BITS-1:0] sample_i,
  input  logic signed [SAMPLE_BITS-1:0] sample_q,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [SAMPLE_BITS-1:0] derot_i,
  output logic signed [SAMPLE_BITS-1:0] derot_q,
  output logic signed [FREQ_BITS-1:0]   freq_estimate,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [CFG_IDX_BITS-1:0]       cfg_index,
  input  logic [GAIN_BITS-1:0]          cfg_data
);

  ccr_cmd_t cmd;
  logic     cfg_we;

  // Take register writes at any time outside reset
  assign cfg_ready = !rst;
  assign cfg_we    = cfg_valid && cfg_ready;

  ccr_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  ccr_datapath #(
    .SAMPLE_BITS   (SAMPLE_BITS),
    .PHASE_BITS    (PHASE_BITS),
    .LUT_ADDR_BITS (LUT_ADDR_BITS),
    .GAIN_SHIFT    (GAIN_SHIFT)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .sample_i      (sample_i),
    .sample_q      (sample_q),
    .derot_i       (derot_i),
    .derot_q       (derot_q),
    .freq_estimate (freq_estimate)
  );

endmodule
